// File: hw/rtl/quaternion_to_pitch_defines.svh
// Assertion macros shared by the quaternion-to-pitch RTL
`ifndef QUATERNION_TO_PITCH_DEFINES_SVH
`define QUATERNION_TO_PITCH_DEFINES_SVH
// Same-cycle implication, checked outside reset
`define Q2P_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define Q2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/q2p_pkg.sv
// Types, constants and table function for the quaternion-to-pitch block
package q2p_pkg;

    localparam int PITCH_FRAC_BITS = 16;
    localparam int OUT_W           = 24;
    localparam int CORDIC_STEPS    = 40;
    localparam int SHIFT_W         = $clog2(CORDIC_STEPS);

    // square root cells: two radicand bits per cell
    localparam int SQ_RAD_W  = 62;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int SQ_CELLS  = SQ_RAD_W / 2;

    localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;

    typedef struct packed {
        logic present;
        logic exceeded;
        logic neg;
    } t_flags;

    typedef struct packed {
        t_flags      flags;
        logic [31:0] aux32;
        logic [63:0] aux64;
    } t_sqrt_tag;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_REM_W-1:0]  rem;
        t_sqrt_tag            tag;
    } t_sqrt;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        t_flags             flags;
    } t_cordic;

    // atan(2^-idx) in Q62 radians: pi/4 for the first step, else a truncated series
    function automatic logic [63:0] atan_q62(input int idx);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        int          sh;
        acc = '0;
        if (idx == 0) begin
            acc = PI_Q60;
        end else begin
            for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
                sh   = idx * (2 * k + 1);
                term = (64'd1 << 62) >> sh;
                term = term / 64'(2 * k + 1);
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/quaternion_to_pitch.sv
// Top level: quaternion sample in, pitch angle in degrees out
//
// Input channel (s_*): one item per unit-quaternion sample. tdata holds the
// vector parts q1, q2, q3 as signed Q2.30; tuser flags that quaternion data
// is present. Output channel (m_*): one item per input item, in order.
// tdata holds the pitch in degrees, signed, PITCH_FRAC_BITS fraction bits;
// tuser flags a computed pitch and a norm above one (root clamped to zero).
// The datapath is one pipeline: squares, a 31-cell square root row for the
// scalar part, the pitch term, a second 31-cell root row for the cosine, a
// 40-cell CORDIC row for the angle and a short scaling tail to degrees.
// One item is taken every cycle unless the row is held. All stages advance
// together: while a result waits at the output and the receiver holds
// i_m_tready low, the whole row holds and o_s_tready drops. Reset clears
// the stage valid bits only; no item is lost or invented across a stall.
module quaternion_to_pitch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // q1 [31:0], q2 [63:32], q3 [95:64]
    input  logic [0:0]  i_s_tuser,   // quat_present [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // pitch_deg [23:0]
    output logic [1:0]  o_m_tuser    // pitch_valid [0], norm_exceeded [1]
);
`include "quaternion_to_pitch_defines.svh"

    localparam int F        = q2p_pkg::PITCH_FRAC_BITS;
    localparam int RW       = q2p_pkg::SQ_ROOT_W;
    localparam int NCELL    = q2p_pkg::SQ_CELLS;
    localparam int NCORD    = q2p_pkg::CORDIC_STEPS;
    localparam int NSTG     = 4 + NCELL + 7 + NCELL + NCORD + 5;
    localparam int OUT_MAX  = (1 << (q2p_pkg::OUT_W - 1)) - 1;
    localparam int CAP_I    = ((90 << F) > OUT_MAX) ? OUT_MAX : (90 << F);
    localparam logic [63:0] ONE60   = 64'd1 << 60;
    localparam logic [63:0] LIM59   = 64'd1 << 59;
    localparam logic [41:0] RND     = 42'd1 << (31 - F);
    localparam logic [33:0] DEG_CAP = 34'(CAP_I);
    localparam logic signed [23:0] PITCH_MAX = 24'(CAP_I);
    localparam logic signed [23:0] PITCH_MIN = -PITCH_MAX;

    logic            w_ce;
    logic [NSTG-1:0] r_vld;

    // input decode
    logic signed [31:0] w_a1, w_a2, w_a3;

    // stage 0: capture, magnitudes
    q2p_pkg::t_flags    r0_flg;
    logic signed [31:0] r0_a1, r0_a2, r0_a3;
    logic [31:0]        r0_m1, r0_m2, r0_m3;
    // stage 1: squares and cross product
    q2p_pkg::t_flags    r1_flg;
    logic [63:0]        r1_sq1, r1_sq2, r1_sq3;
    logic signed [63:0] r1_p31;
    logic signed [31:0] r1_a2;
    // stage 2: sum of squares
    q2p_pkg::t_flags    r2_flg;
    logic [63:0]        r2_sum;
    logic signed [63:0] r2_p31;
    logic signed [31:0] r2_a2;
    // stage 3: root argument
    q2p_pkg::t_sqrt_tag r3_tag;
    logic [61:0]        r3_arg;

    q2p_pkg::t_sqrt     w_sq1_in;
    q2p_pkg::t_sqrt     w_sq1 [NCELL];

    // pitch term stages
    q2p_pkg::t_flags    r4_flg, r5_flg, r6_flg, r7_flg, r8_flg, r9_flg;
    logic signed [63:0] r4_pa, r4_p31;
    logic signed [64:0] r5_d;
    logic [64:0]        w_negd;
    logic [63:0]        r6_mag;
    logic [59:0]        r7_mag;
    logic [60:0]        w_s60;
    logic [RW-1:0]      r8_s30;
    logic [RW-1:0]      r9_s30;
    logic [61:0]        r9_sq;
    q2p_pkg::t_sqrt_tag r10_tag;
    logic [61:0]        r10_arg;

    q2p_pkg::t_sqrt     w_sq2_in;
    q2p_pkg::t_sqrt     w_sq2 [NCELL];

    q2p_pkg::t_cordic   w_cd_in;
    q2p_pkg::t_cordic   w_cd [NCORD];

    // scaling tail
    logic [63:0]        w_zc;
    q2p_pkg::t_flags    r11_flg, r12_flg, r13_flg, r14_flg;
    logic [63:0]        r11_ll, r11_hl, r11_lh, r11_hh;
    logic [33:0]        r12_mid;
    logic [63:0]        r12_hs;
    logic [63:0]        w_quarter;
    logic [33:0]        r13_q32;
    logic [41:0]        w_scaled;
    logic [33:0]        r14_deg;
    logic [33:0]        w_deg_cap;
    logic [23:0]        r_out_pitch;
    logic [1:0]         r_out_user;

    // advance the whole row unless a result is held at the output
    assign w_ce       = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    assign w_a1 = $signed(i_s_tdata[31:0]);
    assign w_a2 = $signed(i_s_tdata[63:32]);
    assign w_a3 = $signed(i_s_tdata[95:64]);

    // front: squares, sum, root argument
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r0_flg.present  <= i_s_tuser[0];
            r0_flg.exceeded <= 1'b0;
            r0_flg.neg      <= 1'b0;
            r0_a1 <= w_a1;
            r0_a2 <= w_a2;
            r0_a3 <= w_a3;
            r0_m1 <= w_a1[31] ? 32'(32'sd0 - w_a1) : 32'(w_a1);
            r0_m2 <= w_a2[31] ? 32'(32'sd0 - w_a2) : 32'(w_a2);
            r0_m3 <= w_a3[31] ? 32'(32'sd0 - w_a3) : 32'(w_a3);

            r1_flg <= r0_flg;
            r1_sq1 <= 64'(r0_m1) * 64'(r0_m1);
            r1_sq2 <= 64'(r0_m2) * 64'(r0_m2);
            r1_sq3 <= 64'(r0_m3) * 64'(r0_m3);
            r1_p31 <= 64'(r0_a3) * 64'(r0_a1);
            r1_a2  <= r0_a2;

            r2_flg <= r1_flg;
            r2_sum <= r1_sq1 + r1_sq2 + r1_sq3;
            r2_p31 <= r1_p31;
            r2_a2  <= r1_a2;

            r3_tag.flags.present  <= r2_flg.present;
            r3_tag.flags.exceeded <= (r2_sum > ONE60);
            r3_tag.flags.neg      <= r2_flg.neg;
            r3_tag.aux32          <= r2_a2;
            r3_tag.aux64          <= r2_p31;
            r3_arg <= (r2_sum > ONE60) ? 62'd0 : 62'(ONE60 - r2_sum);
        end
    end

    // first root row: q0 = floor(sqrt(2^60 - S))
    always_comb begin
        w_sq1_in      = '0;
        w_sq1_in.rad  = r3_arg;
        w_sq1_in.tag  = r3_tag;
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_sq1
        q2p_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_d   ((g == 0) ? w_sq1_in : w_sq1[(g == 0) ? 0 : g - 1]),
            .o_d   (w_sq1[g])
        );
    end

    // pitch term d = q0*q2 - q3*q1, clamp, round to Q30, cosine argument
    assign w_negd = 65'sd0 - r5_d;
    assign w_s60  = {r7_mag, 1'b0} + 61'(RND[29:0] == 30'd0 ? 61'd1 << 29 : 61'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_flg <= w_sq1[NCELL-1].tag.flags;
            r4_pa  <= 64'($signed({1'b0, w_sq1[NCELL-1].root})) *
                      64'($signed(w_sq1[NCELL-1].tag.aux32));
            r4_p31 <= $signed(w_sq1[NCELL-1].tag.aux64);

            r5_flg <= r4_flg;
            r5_d   <= {r4_pa[63], r4_pa} - {r4_p31[63], r4_p31};

            r6_flg.present  <= r5_flg.present;
            r6_flg.exceeded <= r5_flg.exceeded;
            r6_flg.neg      <= r5_d[64];
            r6_mag          <= r5_d[64] ? w_negd[63:0] : r5_d[63:0];

            r7_flg <= r6_flg;
            r7_mag <= (r6_mag > LIM59) ? LIM59[59:0] : r6_mag[59:0];

            r8_flg <= r7_flg;
            r8_s30 <= w_s60[60:30];

            r9_flg <= r8_flg;
            r9_s30 <= r8_s30;
            r9_sq  <= 62'(r8_s30) * 62'(r8_s30);

            r10_tag.flags <= r9_flg;
            r10_tag.aux32 <= 32'(r9_s30);
            r10_tag.aux64 <= '0;
            r10_arg       <= 62'(ONE60) - r9_sq;
        end
    end

    // second root row: c = floor(sqrt(2^60 - s^2))
    always_comb begin
        w_sq2_in      = '0;
        w_sq2_in.rad  = r10_arg;
        w_sq2_in.tag  = r10_tag;
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_sq2
        q2p_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_d   ((g == 0) ? w_sq2_in : w_sq2[(g == 0) ? 0 : g - 1]),
            .o_d   (w_sq2[g])
        );
    end

    // CORDIC row on (c<<24, s<<24)
    always_comb begin
        w_cd_in       = '0;
        w_cd_in.x     = $signed({{(64 - RW - 24){1'b0}}, w_sq2[NCELL-1].root, 24'd0});
        w_cd_in.y     = $signed({{(64 - RW - 24){1'b0}},
                                 w_sq2[NCELL-1].tag.aux32[RW-1:0], 24'd0});
        w_cd_in.flags = w_sq2[NCELL-1].tag.flags;
    end

    for (genvar g = 0; g < NCORD; g++) begin : g_cd
        localparam logic [63:0] ATAN_G = q2p_pkg::atan_q62(g);
        q2p_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_shift (q2p_pkg::SHIFT_W'(g)),
            .i_atan  (ATAN_G),
            .i_d     ((g == 0) ? w_cd_in : w_cd[(g == 0) ? 0 : g - 1]),
            .o_d     (w_cd[g])
        );
    end

    // angle to quarter turns (high half of z * 2/pi), then degrees
    assign w_zc      = w_cd[NCORD-1].z[63] ? 64'd0 : w_cd[NCORD-1].z;
    assign w_quarter = r12_hs + 64'(r12_mid[33:32]);
    assign w_scaled  = 42'(r13_q32) * 42'd90 + RND;
    assign w_deg_cap = (r14_deg > DEG_CAP) ? DEG_CAP : r14_deg;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r11_flg <= w_cd[NCORD-1].flags;
            r11_ll  <= 64'(w_zc[31:0])  * 64'(q2p_pkg::TWO_OVER_PI_Q64[31:0]);
            r11_hl  <= 64'(w_zc[63:32]) * 64'(q2p_pkg::TWO_OVER_PI_Q64[31:0]);
            r11_lh  <= 64'(w_zc[31:0])  * 64'(q2p_pkg::TWO_OVER_PI_Q64[63:32]);
            r11_hh  <= 64'(w_zc[63:32]) * 64'(q2p_pkg::TWO_OVER_PI_Q64[63:32]);

            r12_flg <= r11_flg;
            r12_mid <= 34'(r11_ll[63:32]) + 34'(r11_hl[31:0]) + 34'(r11_lh[31:0]);
            r12_hs  <= r11_hh + 64'(r11_hl[63:32]) + 64'(r11_lh[63:32]);

            r13_flg <= r12_flg;
            r13_q32 <= w_quarter[63:30];

            r14_flg <= r13_flg;
            r14_deg <= 34'(w_scaled >> (32 - F));

            // output register: drop everything when no quaternion data came in
            if (r14_flg.present) begin
                r_out_pitch <= r14_flg.neg ? 24'(24'd0 - w_deg_cap[23:0]) : w_deg_cap[23:0];
                r_out_user  <= {r14_flg.exceeded, 1'b1};
            end else begin
                r_out_pitch <= '0;
                r_out_user  <= '0;
            end
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = r_out_pitch;
    assign o_m_tuser  = r_out_user;

    `Q2P_ASSERT_IMPL(a_absent_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0],
        o_m_tdata == 24'd0 && !o_m_tuser[1], "forced result not all zero")
    `Q2P_ASSERT_IMPL(a_exceed_valid, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1],
        o_m_tuser[0], "norm flag without computed pitch")
    `Q2P_ASSERT_IMPL(a_pitch_range, i_clk, i_rst_n, o_m_tvalid,
        $signed(o_m_tdata) <= PITCH_MAX && $signed(o_m_tdata) >= PITCH_MIN, "pitch beyond cap")
    `Q2P_ASSERT_NEXT(a_hold_row, i_clk, i_rst_n, !w_ce,
        r_vld == $past(r_vld), "stage valid bits moved during a stall")

endmodule

// File: hw/rtl/q2p_sqrt_cell.sv
// One digit cell of the pipelined integer square root
module q2p_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_ce,
    input  q2p_pkg::t_sqrt  i_d,
    output q2p_pkg::t_sqrt  o_d
);
    logic [q2p_pkg::SQ_REM_W+1:0] w_part;
    logic [q2p_pkg::SQ_REM_W+1:0] w_trial;
    logic [q2p_pkg::SQ_REM_W+1:0] w_diff;
    logic                         w_take;
    q2p_pkg::t_sqrt               n_d;
    q2p_pkg::t_sqrt               r_d;

    // bring down the next two radicand bits and try a one digit
    assign w_part  = {i_d.rem, i_d.rad[q2p_pkg::SQ_RAD_W-1 -: 2]};
    assign w_trial = {{(q2p_pkg::SQ_REM_W - q2p_pkg::SQ_ROOT_W){1'b0}}, i_d.root, 2'b01};
    assign w_diff  = w_part - w_trial;
    assign w_take  = (w_part >= w_trial);

    always_comb begin
        n_d      = i_d;
        n_d.rad  = {i_d.rad[q2p_pkg::SQ_RAD_W-3:0], 2'b00};
        n_d.root = {i_d.root[q2p_pkg::SQ_ROOT_W-2:0], w_take};
        n_d.rem  = w_take ? w_diff[q2p_pkg::SQ_REM_W-1:0] : w_part[q2p_pkg::SQ_REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: hw/rtl/q2p_cordic_cell.sv
// One vectoring rotation cell of the pipelined CORDIC
module q2p_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [q2p_pkg::SHIFT_W-1:0]   i_shift,
    input  logic [63:0]                   i_atan,
    input  q2p_pkg::t_cordic              i_d,
    output q2p_pkg::t_cordic              o_d
);
    logic signed [63:0] w_dx;
    logic signed [63:0] w_dy;
    q2p_pkg::t_cordic   n_d;
    q2p_pkg::t_cordic   r_d;

    assign w_dx = i_d.y >>> i_shift;
    assign w_dy = i_d.x >>> i_shift;

    // rotate towards the x axis
    always_comb begin
        n_d = i_d;
        if (i_d.y > 64'sd0) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + $signed(i_atan);
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - $signed(i_atan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the quaternion-to-pitch block
module tb_top;

    typedef struct {
        bit          present;
        logic [31:0] q1;
        logic [31:0] q2;
        logic [31:0] q3;
        bit          drain;   // hold this item back until every result is in
    } t_sample;

    typedef struct {
        logic [23:0] pitch;
        logic        computed;
        logic        exceeded;
    } t_pitch;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;   // q1 [31:0], q2 [63:32], q3 [95:64]
    logic [0:0]  i_s_tuser;   // quat_present [0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // pitch_deg [23:0]
    logic [1:0]  o_m_tuser;   // pitch_valid [0], norm_exceeded [1]

    t_sample     pending_q[$];
    t_pitch      pitch_q[$];
    longint      atan_q62[q2p_pkg::CORDIC_STEPS];
    int          n_sent;
    int          n_got;
    int          n_fail;
    int          stall_left;
    bit          stall_done;
    bit          quiet;

    quaternion_to_pitch u_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // atan(2^-i) in Q62 radians by the alternating series, truncated terms
    function automatic longint atan_step(int i);
        longint acc;
        longint unsigned t;
        int k;
        acc = 0;
        if (i == 0) begin
            return longint'(q2p_pkg::PI_Q60);
        end
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            t = ((64'd1 << 62) >> (i * (2 * k + 1))) / longint'(2 * k + 1);
            acc = k[0] ? acc - longint'(t) : acc + longint'(t);
        end
        return acc;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_pitch pitch_of(bit present, logic [31:0] r1, logic [31:0] r2,
                                        logic [31:0] r3);
        t_pitch          r;
        longint          a1, a2, a3, d, x, y, z, dx, dy;
        longint unsigned m1, m2, m3, sum, q0, s30, c30, q32, deg;
        logic [127:0]    prod;
        bit              exc, neg;
        r = '{24'd0, 1'b0, 1'b0};
        if (!present) return r;
        a1 = longint'(signed'(r1));
        a2 = longint'(signed'(r2));
        a3 = longint'(signed'(r3));
        m1 = a1 < 0 ? -a1 : a1;
        m2 = a2 < 0 ? -a2 : a2;
        m3 = a3 < 0 ? -a3 : a3;
        sum = m1 * m1 + m2 * m2 + m3 * m3;
        exc = sum > (64'd1 << 60);
        q0 = root_floor(exc ? 64'd0 : (64'd1 << 60) - sum);
        d = longint'(q0) * a2 - a3 * a1;
        // clamp so that twice the term stays within one
        if (d > (64'sd1 <<< 59)) d = 64'sd1 <<< 59;
        if (d < -(64'sd1 <<< 59)) d = -(64'sd1 <<< 59);
        neg = d < 0;
        s30 = (2 * longint'(neg ? -d : d) + (64'd1 << 29)) >> 30;
        c30 = root_floor((64'd1 << 60) - s30 * s30);
        x = longint'(c30 << 24);
        y = longint'(s30 << 24);
        z = 0;
        for (int i = 0; i < q2p_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_q62[i];
            end else begin
                x -= dx; y += dy; z -= atan_q62[i];
            end
        end
        if (z < 0) z = 0;
        prod = 128'(longint'(z)) * 128'(q2p_pkg::TWO_OVER_PI_Q64);
        q32 = prod[127:64] >> 30;
        deg = (q32 * 90 + (64'd1 << (31 - q2p_pkg::PITCH_FRAC_BITS)))
              >> (32 - q2p_pkg::PITCH_FRAC_BITS);
        if (deg > (64'd90 << q2p_pkg::PITCH_FRAC_BITS)) deg = 64'd90 << q2p_pkg::PITCH_FRAC_BITS;
        if (deg > 64'h7FFFFF) deg = 64'h7FFFFF;
        r.pitch = neg ? 24'(-deg) : 24'(deg);
        r.computed = 1'b1;
        r.exceeded = exc;
        return r;
    endfunction

    function automatic logic [31:0] unit_part();
        return 32'($urandom_range(1240000000)) - 32'd620000000;
    endfunction

    task automatic add_sample(bit p, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              bit drain = 0);
        pending_q.push_back('{p, a, b, c, drain});
    endtask

    // stimulus: directed corners, then mostly unit quaternions with some raw noise
    initial begin
        int pick;
        for (int i = 0; i < q2p_pkg::CORDIC_STEPS; i++) atan_q62[i] = atan_step(i);
        add_sample(0, $urandom, $urandom, $urandom);
        add_sample(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_sample(1, 0, 0, 0);
        add_sample(1, 0, 32'h4000_0000, 0);
        add_sample(1, 0, 32'hC000_0000, 0);
        add_sample(1, 32'h2D41_3CCD, 32'h2D41_3CCD, 0);
        add_sample(1, 32'h2D41_3CCD, 32'hD2BE_C333, 0);
        add_sample(1, 32'h2D41_3CCD, 0, 32'hD2BE_C333);
        add_sample(1, 32'h2D41_3CCD, 0, 32'h2D41_3CCD);
        add_sample(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_sample(1, 32'h7FFF_FFFF, 0, 32'h8000_0000);
        add_sample(1, 32'h8000_0000, 0, 32'h8000_0000);
        add_sample(1, 32'h4000_0000, 0, 0);
        add_sample(1, 32'h4000_0001, 0, 0);
        add_sample(1, 0, 32'h2000_0000, 0);
        add_sample(1, 0, 32'hE000_0000, 32'h0000_0001);
        add_sample(1, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int n = 0; n < 1400; n++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                add_sample(0, $urandom, $urandom, $urandom, n == 700);
            else if (pick < 20)
                add_sample(1, $urandom, $urandom, $urandom, n == 700);
            else
                add_sample(1, unit_part(), unit_part(), unit_part(), n == 700);
        end
    end

    // sender: advance to the next item when the current one is taken
    always @(posedge i_clk) begin
        bit     go;
        t_sample s;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            go = pending_q.size() != 0 && (quiet || $urandom_range(99) >= 17);
            if (go && pending_q[0].drain && (i_s_tvalid || pitch_q.size() != 0)) go = 0;
            if (go) begin
                s = pending_q.pop_front();
                i_s_tdata <= {s.q3, s.q2, s.q1};
                i_s_tuser <= s.present;
            end
            i_s_tvalid <= go;
        end
    end

    // stretch with no idling on either side
    assign quiet = n_sent >= 900 && n_sent < 1150;

    // receiver: random idling plus one long hold-off to fill the pipeline
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!stall_done && n_sent >= 300) begin
            stall_done <= 1'b1;
            stall_left <= 400;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || $urandom_range(99) >= 17;
        end
    end

    // monitor: predict on input acceptance, compare on output acceptance
    always @(posedge i_clk) begin
        t_pitch want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pitch_q.push_back(pitch_of(i_s_tuser[0], i_s_tdata[31:0], i_s_tdata[63:32],
                                           i_s_tdata[95:64]));
                n_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_got++;
                if (pitch_q.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, o_m_tdata, o_m_tuser);
                    n_fail++;
                end else begin
                    want = pitch_q.pop_front();
                    if (o_m_tdata !== want.pitch) begin
                        $display("%0t: pitch exp %h got %h", $time, want.pitch, o_m_tdata);
                        n_fail++;
                    end
                    if (o_m_tuser[0] !== want.computed) begin
                        $display("%0t: pitch_valid exp %b got %b", $time, want.computed,
                                 o_m_tuser[0]);
                        n_fail++;
                    end
                    if (o_m_tuser[1] !== want.exceeded) begin
                        $display("%0t: norm_exceeded exp %b got %b", $time, want.exceeded,
                                 o_m_tuser[1]);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        n_sent = 0;
        n_got  = 0;
        n_fail = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        #100;
        wait (pending_q.size() == 0 && !i_s_tvalid && pitch_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0 && pitch_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/q2p_pkg.sv
hw/rtl/q2p_sqrt_cell.sv
hw/rtl/q2p_cordic_cell.sv
hw/rtl/quaternion_to_pitch.sv
sim/tb_top.sv
